// ===== rtl/gemt_pkg.sv =====
// Shared constants, types and helpers for the group endpoint membership table.
package gemt_pkg;

  localparam int GROUPS    = 16;
  localparam int ENDPOINTS = 256;
  localparam int WORDS     = (ENDPOINTS + 63) / 64;

  localparam int KIND_W   = 3;
  localparam int GID_W    = 16;
  localparam int EP_W     = 8;
  localparam int STATUS_W = 3;
  localparam int WIDX_W   = 2;
  localparam int MASK_W   = 64;
  localparam int BITPOS_W = 6;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 72;

  // Every entry owns four word addresses, whatever the endpoint count.
  localparam int SLOT_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int MEM_DEPTH = GROUPS * 4;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(GROUPS - 1);
  localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);

  localparam logic [KIND_W-1:0] KIND_ADD        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_ALL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE       = 3'd0,
    STAT_FULL       = 3'd1,
    STAT_ALREADY    = 3'd2,
    STAT_NOGROUP    = 3'd3,
    STAT_NOTMEMBER  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_REMOVE_ALL,
    OP_QUERY,
    OP_LOOKUP,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [GID_W-1:0]    group_id;
    logic                ep_ok;
    logic [WIDX_W-1:0]   wsel;
    logic [BITPOS_W-1:0] bitpos;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CREATE,
    S_MODIFY,
    S_WALK_RD,
    S_WALK_WR,
    S_LK_RD,
    S_LK_OUT,
    S_EMIT
  } state_t;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [WIDX_W-1:0] w);
    return ADDR_W'({slot, w});
  endfunction

endpackage

// ===== rtl/gemt_front.sv =====
// Front end: accepts requests, decodes the kind and splits the endpoint number.
module gemt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gemt_pkg::IN_DATA_W-1:0] s_tdata,  // group_id[15:0], endpoint[23:16]
  input  logic [gemt_pkg::KIND_W-1:0]    s_tuser,  // kind[2:0]
  output logic                           q_valid,
  input  logic                           q_ready,
  output gemt_pkg::cmd_t                 q_cmd
);
  import gemt_pkg::*;

  logic            f_valid;
  cmd_t            f_cmd;
  cmd_t            dec;
  logic [EP_W-1:0] ep;

  assign ep = s_tdata[GID_W +: EP_W];

  always_comb begin
    unique case (s_tuser)
      KIND_ADD:        dec.op = OP_ADD;
      KIND_REMOVE:     dec.op = OP_REMOVE;
      KIND_REMOVE_ALL: dec.op = OP_REMOVE_ALL;
      KIND_QUERY:      dec.op = OP_QUERY;
      KIND_LOOKUP:     dec.op = OP_LOOKUP;
      default:         dec.op = OP_IGNORE;
    endcase
    dec.group_id = s_tdata[GID_W-1:0];
    dec.ep_ok    = ({1'b0, ep} < (EP_W + 1)'(ENDPOINTS));
    dec.wsel     = ep[EP_W-1 -: WIDX_W];
    dec.bitpos   = ep[BITPOS_W-1:0];
  end

  assign s_tready = !f_valid || q_ready;
  assign q_valid  = f_valid;
  assign q_cmd    = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tready) begin
      f_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      f_cmd <= dec;
    end
  end

endmodule

// ===== rtl/gemt_queue.sv =====
// Short request queue between the front end and the table engine.
module gemt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gemt_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output gemt_pkg::cmd_t out_cmd
);
  import gemt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== rtl/gemt_back.sv =====
// Table engine: group match, mask word memory, update sequencer and result register.
module gemt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  gemt_pkg::cmd_t                  q_cmd,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [gemt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import gemt_pkg::*;

  state_t state;
  state_t state_next;
  cmd_t   cmd;

  logic [GROUPS-1:0] entry_valid;
  logic [GID_W-1:0]  entry_group [GROUPS];
  logic [3:0]        word_nz     [GROUPS];

  logic [MASK_W-1:0] mem [MEM_DEPTH];
  logic [MASK_W-1:0] rdata;

  logic [SLOT_W-1:0] slot;
  logic [WIDX_W-1:0] cnt_w;
  logic              removed;
  logic              res_ok;
  status_t           res_status;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_any;
  logic [SLOT_W-1:0] free_slot;

  logic              out_free;
  logic              rd_bit;
  logic [MASK_W-1:0] bit_mask;
  logic [3:0]        nz_upd;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [MASK_W-1:0] wr_data;
  logic              out_load;
  logic              res_load;
  logic              res_ok_d;
  status_t           res_status_d;
  logic              out_ok;
  status_t           out_status;
  logic [WIDX_W-1:0] out_widx;
  logic [MASK_W-1:0] out_mask;
  logic              out_last;

  assign out_free = !m_tvalid || m_tready;
  assign rd_bit   = rdata[cmd.bitpos];
  assign bit_mask = MASK_W'(1) << cmd.bitpos;

  // Group match and lowest free slot; a group id is held by at most one valid entry.
  always_comb begin
    hit       = 1'b0;
    hit_slot  = '0;
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_group[i] == cmd.group_id) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!entry_valid[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    nz_upd             = word_nz[slot];
    nz_upd[cmd.wsel]   = (wr_data != '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (cmd.op)
          OP_ADD: begin
            if (!cmd.ep_ok) begin
              state_next = S_EMIT;
            end else if (hit) begin
              state_next = S_MODIFY;
            end else if (free_any) begin
              state_next = S_CREATE;
            end else begin
              state_next = S_EMIT;
            end
          end
          OP_REMOVE:          state_next = (hit && cmd.ep_ok) ? S_MODIFY : S_EMIT;
          OP_REMOVE_ALL:      state_next = cmd.ep_ok ? S_WALK_RD : S_EMIT;
          OP_LOOKUP:          state_next = hit ? S_LK_RD : S_EMIT;
          OP_QUERY, OP_IGNORE: state_next = S_EMIT;
        endcase
      end
      S_CREATE: begin
        if (cnt_w == 2'd3) begin
          state_next = S_EMIT;
        end
      end
      S_MODIFY:  state_next = S_EMIT;
      S_WALK_RD: state_next = S_WALK_WR;
      S_WALK_WR: state_next = (slot == LAST_SLOT) ? S_EMIT : S_WALK_RD;
      S_LK_RD:   state_next = S_LK_OUT;
      S_LK_OUT: begin
        if (out_free) begin
          state_next = (cnt_w == LAST_WORD) ? S_IDLE : S_LK_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    q_ready      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = word_addr(slot, cmd.wsel);
    wr_data      = '0;
    out_load     = 1'b0;
    res_load     = 1'b0;
    res_ok_d     = 1'b0;
    res_status_d = STAT_DONE;
    out_ok       = res_ok;
    out_status   = res_status;
    out_widx     = '0;
    out_mask     = '0;
    out_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
      end
      S_DECIDE: begin
        res_load = 1'b1;
        unique case (cmd.op)
          OP_ADD: begin
            if (!cmd.ep_ok) begin
              res_status_d = STAT_NOTMEMBER;
            end else if (hit) begin
              rd_en   = 1'b1;
              rd_addr = word_addr(hit_slot, cmd.wsel);
            end else if (free_any) begin
              res_ok_d = 1'b1;
            end else begin
              res_status_d = STAT_FULL;
            end
          end
          OP_REMOVE: begin
            if (!hit) begin
              res_status_d = STAT_NOGROUP;
            end else if (!cmd.ep_ok) begin
              res_status_d = STAT_NOTMEMBER;
            end else begin
              rd_en   = 1'b1;
              rd_addr = word_addr(hit_slot, cmd.wsel);
            end
          end
          OP_REMOVE_ALL: begin
            res_status_d = STAT_NOTMEMBER;
          end
          OP_QUERY: begin
            res_ok_d     = hit;
            res_status_d = hit ? STAT_DONE : STAT_NOGROUP;
          end
          OP_LOOKUP: begin
            res_status_d = STAT_NOGROUP;
          end
          OP_IGNORE: begin
            res_status_d = STAT_DONE;
          end
        endcase
      end
      S_CREATE: begin
        wr_en   = 1'b1;
        wr_addr = word_addr(slot, cnt_w);
        wr_data = (cnt_w == cmd.wsel) ? bit_mask : '0;
      end
      S_MODIFY: begin
        res_load = 1'b1;
        if (cmd.op == OP_ADD) begin
          wr_en        = !rd_bit;
          wr_data      = rdata | bit_mask;
          res_ok_d     = !rd_bit;
          res_status_d = rd_bit ? STAT_ALREADY : STAT_DONE;
        end else begin
          wr_en        = rd_bit;
          wr_data      = rdata & ~bit_mask;
          res_ok_d     = rd_bit;
          res_status_d = rd_bit ? STAT_DONE : STAT_NOTMEMBER;
        end
      end
      S_WALK_RD: begin
        rd_en   = 1'b1;
        rd_addr = word_addr(slot, cmd.wsel);
      end
      S_WALK_WR: begin
        wr_en        = entry_valid[slot] && rd_bit;
        wr_data      = rdata & ~bit_mask;
        res_load     = (slot == LAST_SLOT);
        res_ok_d     = removed || wr_en;
        res_status_d = (removed || wr_en) ? STAT_DONE : STAT_NOTMEMBER;
      end
      S_LK_RD: begin
        rd_en   = 1'b1;
        rd_addr = word_addr(slot, cnt_w);
      end
      S_LK_OUT: begin
        out_load   = out_free;
        out_ok     = 1'b1;
        out_status = STAT_DONE;
        out_widx   = cnt_w;
        out_mask   = rdata;
        out_last   = (cnt_w == LAST_WORD);
      end
      S_EMIT: begin
        out_load = out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_valid <= '0;
      m_tvalid    <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        word_nz[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_DECIDE && cmd.op == OP_ADD && cmd.ep_ok && !hit && free_any) begin
        entry_valid[free_slot] <= 1'b1;
        word_nz[free_slot]     <= 4'b0001 << cmd.wsel;
      end
      if ((state == S_MODIFY || state == S_WALK_WR) && wr_en) begin
        word_nz[slot] <= nz_upd;
        if (nz_upd == '0) begin
          entry_valid[slot] <= 1'b0;
        end
      end
    end

    if (q_ready && q_valid) begin
      cmd <= q_cmd;
    end
    if (res_load) begin
      res_ok     <= res_ok_d;
      res_status <= res_status_d;
    end
    if (out_load) begin
      m_tdata <= {2'b00, out_mask, out_widx, out_status, out_ok};
      m_tlast <= out_last;
    end

    unique case (state)
      S_DECIDE: begin
        cnt_w   <= '0;
        removed <= 1'b0;
        if (cmd.op == OP_REMOVE_ALL) begin
          slot <= '0;
        end else if (hit) begin
          slot <= hit_slot;
        end else begin
          slot <= free_slot;
        end
        if (cmd.op == OP_ADD && !hit && free_any) begin
          entry_group[free_slot] <= cmd.group_id;
        end
      end
      S_CREATE: begin
        cnt_w <= cnt_w + 1'b1;
      end
      S_WALK_WR: begin
        removed <= removed || wr_en;
        slot    <= slot + 1'b1;
      end
      S_LK_OUT: begin
        if (out_free) begin
          cnt_w <= cnt_w + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/group_endpoint_membership_table_top.sv =====
// Top level of the group endpoint membership table.
//
// The block keeps up to 16 groups, each a 16-bit group id with a 256-bit
// endpoint membership mask held as four 64-bit words in an internal memory.
// A request carries the kind in s_tuser and the group id and endpoint in
// s_tdata; each request produces one result, except a lookup of an existing
// group, which produces one result per mask word with the final one marked by
// m_tlast. A front end decodes requests into a two-entry queue, so new
// requests are taken while the table engine is busy and while a result waits
// on m_tready. The table engine handles one request at a time: a query, an
// ignored kind or a refused request goes straight to its result; an add or
// remove on an existing group reads the mask word and then updates it; an
// add that creates a group clears the entry's four words one per cycle
// through the single write port; a lookup reads and emits the four words in
// turn; a remove-all reads and then rewrites the endpoint's word of each of
// the 16 entries in turn. A waiting result holds the engine. A group whose
// mask becomes empty is freed, and an add creates a group in the lowest free
// entry. No clearing pass is needed after reset: entries start invalid and
// the memory words of an entry are written when the entry is created.
module group_endpoint_membership_table_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [gemt_pkg::IN_DATA_W-1:0]  s_tdata,  // group_id[15:0], endpoint[23:16]
  input  logic [gemt_pkg::KIND_W-1:0]     s_tuser,  // kind[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // ok[0], status[3:1], word_index[5:4], endpoint_mask[69:6], zero pad[71:70]
  output logic [gemt_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import gemt_pkg::*;

  // Decoded requests flow front end -> queue -> table engine.
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  // The front end registers each request with its decoded operation and the
  // word select and bit position of the endpoint.
  gemt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_cmd    (fq_cmd)
  );

  gemt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_cmd    (fq_cmd),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_cmd   (qb_cmd)
  );

  // The table engine owns all table state and the output register.
  gemt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_cmd    (qb_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
